FILE: design/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   localparam int CW            = 16;  // component width, Q2.(CW-2)
   localparam int CORDIC_STAGES = 16;
   localparam int GFRAC         = 20;  // working fraction bits
   localparam int PROD_SHIFT    = 2 * (CW - 2) - GFRAC;
   localparam int PW            = 2 * CW - PROD_SHIFT;  // floored product width
   localparam int GW            = 28;  // cordic vector width
   localparam int ZW            = 20;  // Q.16 angle accumulator width
   localparam int SQW           = 43;  // square root working width
   localparam int SQ_STEPS      = 21;  // root digits of a value below 4^21
   localparam int LATENCY       = 3 + SQ_STEPS + 1 + CORDIC_STAGES + 1;

   localparam logic signed [GW-1:0] ONE_G       = GW'(1) <<< GFRAC;
   localparam logic signed [ZW-1:0] HALF_PI_Q16 = ZW'(102944);
   localparam logic signed [15:0]   PI_Q13      = 16'sd25736;
   localparam logic signed [15:0]   HALF_PI_Q13 = 16'sd12868;

   typedef struct packed {
      logic                   zero;
      logic signed [GW-1:0]   x;
      logic signed [GW-1:0]   y;
      logic signed [ZW-1:0]   z;
   } cordic_vec_type;

   typedef struct packed {
      logic [SQW-1:0] v;
      logic [SQW-1:0] r;
   } sqrt_state_type;

   function automatic logic signed [ZW-1:0] atan_q16(input int idx);
      logic signed [ZW-1:0] a;
      case (idx)
         0:  a = ZW'(51472);
         1:  a = ZW'(30386);
         2:  a = ZW'(16055);
         3:  a = ZW'(8150);
         4:  a = ZW'(4091);
         5:  a = ZW'(2047);
         6:  a = ZW'(1024);
         7:  a = ZW'(512);
         8:  a = ZW'(256);
         9:  a = ZW'(128);
         10: a = ZW'(64);
         11: a = ZW'(32);
         12: a = ZW'(16);
         13: a = ZW'(8);
         14: a = ZW'(4);
         15: a = ZW'(2);
         16: a = ZW'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

   // turn a left half-plane vector by +-pi/2 into the right half-plane
   function automatic cordic_vec_type prerotate(input logic signed [GW-1:0] x,
                                                input logic signed [GW-1:0] y);
      cordic_vec_type o;
      o.zero = (x == '0) && (y == '0);
      o.x    = x;
      o.y    = y;
      o.z    = '0;
      if (x < 0) begin
         if (y >= 0) begin
            o.x = y;
            o.y = -x;
            o.z = HALF_PI_Q16;
         end else begin
            o.x = -y;
            o.y = x;
            o.z = -HALF_PI_Q16;
         end
      end
      return o;
   endfunction

endpackage
`default_nettype wire

FILE: design/q2e_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt_cell import q2e_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic [4:0]     step_idx,
   input  wire logic           in_valid,
   input  wire sqrt_state_type in_st,
   output logic                out_valid,
   output sqrt_state_type      out_st
);

   logic           valid_ff, valid_in;
   sqrt_state_type st_ff, st_in;
   logic [SQW-1:0] bit_w, rb;

   always_comb begin
      bit_w    = SQW'(1) << {step_idx, 1'b0};
      rb       = in_st.r + bit_w;
      valid_in = in_valid;
      st_in    = in_st;
      if (in_st.v >= rb) begin
         st_in.v = in_st.v - rb;
         st_in.r = (in_st.r >> 1) + bit_w;
      end else begin
         st_in.r = in_st.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      st_ff <= st_in;
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;

endmodule
`default_nettype wire

FILE: design/q2e_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell import q2e_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [4:0]           stage_idx,
   input  wire logic signed [ZW-1:0] atan_val,
   input  wire logic                 in_valid,
   input  wire cordic_vec_type       in_vec,
   output logic                      out_valid,
   output cordic_vec_type            out_vec
);

   logic                 valid_ff, valid_in;
   cordic_vec_type       vec_ff, vec_in;
   logic signed [GW-1:0] dx, dy;

   always_comb begin
      dx       = in_vec.y >>> stage_idx;
      dy       = in_vec.x >>> stage_idx;
      valid_in = in_valid;
      vec_in   = in_vec;
      if (in_vec.y > 0) begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + atan_val;
      end else begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - atan_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      vec_ff <= vec_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule
`default_nettype wire

FILE: design/quaternion_to_euler.sv
`timescale 1ns / 1ps
`default_nettype none
// quaternion to ZYX euler angles (roll, pitch, yaw)
// input channel: drive req_qw/qx/qy/qz (signed Q2.14) and raise start; an item
// is taken at each rising edge with start high and busy low. busy is always low,
// so a new quaternion may enter every cycle.
// result channel: rsp_valid is high for one cycle with rsp_roll and rsp_yaw
// (signed Q3.13 radians) and rsp_pitch (signed Q2.13 radians); the receiver
// has no way to stall, so each result must be captured in that cycle.
// throughput: one item per cycle.
// the path is input register, product register, sum register, two rows of 21
// square root cells (pitch operands), a pre-rotation register, three rows of 16
// cordic cells and an output register; the length is set by the cell rows.
// results stay in order, one per item.
// reset: synchronous, clears the valid bits along the rows; items in flight
// are dropped, no result comes out until new items have passed through.
module quaternion_to_euler import q2e_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic signed [CW-1:0] req_qw,
   input  wire logic signed [CW-1:0] req_qx,
   input  wire logic signed [CW-1:0] req_qy,
   input  wire logic signed [CW-1:0] req_qz,
   output logic                      rsp_valid,
   output logic signed [15:0]        rsp_roll,
   output logic signed [14:0]        rsp_pitch,
   output logic signed [15:0]        rsp_yaw
);

   typedef struct packed {
      logic signed [GW-1:0] sr;
      logic signed [GW-1:0] cr;
      logic signed [GW-1:0] sy;
      logic signed [GW-1:0] cy;
   } rpy_vec_type;

   assign busy = 1'b0;

   // input register
   logic                 in_valid_ff;
   logic signed [CW-1:0] w_ff, x_ff, y_ff, z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      w_ff <= req_qw;
      x_ff <= req_qx;
      y_ff <= req_qy;
      z_ff <= req_qz;
   end

   // floored products
   function automatic logic signed [PW-1:0] mulg(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
      logic signed [2*CW-1:0] p;
      p = a * b;
      return PW'(p >>> PROD_SHIFT);
   endfunction

   logic                 prod_valid_ff;
   logic signed [PW-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wz_ff, xy_ff, zz_ff, wy_ff, xz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= in_valid_ff;
      end
      wx_ff <= mulg(w_ff, x_ff);
      yz_ff <= mulg(y_ff, z_ff);
      xx_ff <= mulg(x_ff, x_ff);
      yy_ff <= mulg(y_ff, y_ff);
      wz_ff <= mulg(w_ff, z_ff);
      xy_ff <= mulg(x_ff, y_ff);
      zz_ff <= mulg(z_ff, z_ff);
      wy_ff <= mulg(w_ff, y_ff);
      xz_ff <= mulg(x_ff, z_ff);
   end

   // sums and pitch operands
   rpy_vec_type          sum_in, sum_ff;
   sqrt_state_type       sp_in, cp_in, sp_ff, cp_ff;
   logic signed [GW-1:0] s_raw, s_clamp;
   logic                 sum_valid_ff;

   always_comb begin
      sum_in.sr = (GW'(wx_ff) + GW'(yz_ff)) <<< 1;
      sum_in.cr = ONE_G - ((GW'(xx_ff) + GW'(yy_ff)) <<< 1);
      sum_in.sy = (GW'(wz_ff) + GW'(xy_ff)) <<< 1;
      sum_in.cy = ONE_G - ((GW'(yy_ff) + GW'(zz_ff)) <<< 1);
      s_raw     = (GW'(wy_ff) - GW'(xz_ff)) <<< 1;
      s_clamp   = s_raw;
      if (s_raw > ONE_G) begin
         s_clamp = ONE_G;
      end
      if (s_raw < -ONE_G) begin
         s_clamp = -ONE_G;
      end
      sp_in.v = SQW'(ONE_G + s_clamp) << GFRAC;
      sp_in.r = '0;
      cp_in.v = SQW'(ONE_G - s_clamp) << GFRAC;
      cp_in.r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= prod_valid_ff;
      end
      sum_ff <= sum_in;
      sp_ff  <= sp_in;
      cp_ff  <= cp_in;
   end

   // square root rows, roll and yaw operands ride alongside
   logic           sq_valid [SQ_STEPS+1];
   logic           sq_valid_b [SQ_STEPS+1];
   sqrt_state_type sp_st [SQ_STEPS+1];
   sqrt_state_type cp_st [SQ_STEPS+1];
   rpy_vec_type    del_ff [SQ_STEPS];

   assign sq_valid[0]   = sum_valid_ff;
   assign sq_valid_b[0] = sum_valid_ff;
   assign sp_st[0]      = sp_ff;
   assign cp_st[0]      = cp_ff;

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      q2e_sqrt_cell u_sp (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (5'(SQ_STEPS - 1 - k)),
         .in_valid  (sq_valid[k]),
         .in_st     (sp_st[k]),
         .out_valid (sq_valid[k+1]),
         .out_st    (sp_st[k+1])
      );
      q2e_sqrt_cell u_cp (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (5'(SQ_STEPS - 1 - k)),
         .in_valid  (sq_valid_b[k]),
         .in_st     (cp_st[k]),
         .out_valid (sq_valid_b[k+1]),
         .out_st    (cp_st[k+1])
      );
      always_ff @(posedge clock) begin
         if (k == 0) begin
            del_ff[k] <= sum_ff;
         end else begin
            del_ff[k] <= del_ff[k-1];
         end
      end
   end

   // pre-rotation
   logic           pre_valid_ff;
   cordic_vec_type pre_r_ff, pre_p_ff, pre_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= sq_valid[SQ_STEPS] && sq_valid_b[SQ_STEPS];
      end
      pre_r_ff <= prerotate(del_ff[SQ_STEPS-1].cr, del_ff[SQ_STEPS-1].sr);
      pre_y_ff <= prerotate(del_ff[SQ_STEPS-1].cy, del_ff[SQ_STEPS-1].sy);
      pre_p_ff <= prerotate(GW'(cp_st[SQ_STEPS].r), GW'(sp_st[SQ_STEPS].r));
   end

   // cordic rows
   logic           cr_valid [CORDIC_STAGES+1];
   logic           cp_valid [CORDIC_STAGES+1];
   logic           cy_valid [CORDIC_STAGES+1];
   cordic_vec_type r_vec [CORDIC_STAGES+1];
   cordic_vec_type p_vec [CORDIC_STAGES+1];
   cordic_vec_type y_vec [CORDIC_STAGES+1];

   assign cr_valid[0] = pre_valid_ff;
   assign cp_valid[0] = pre_valid_ff;
   assign cy_valid[0] = pre_valid_ff;
   assign r_vec[0]    = pre_r_ff;
   assign p_vec[0]    = pre_p_ff;
   assign y_vec[0]    = pre_y_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      q2e_cordic_cell u_roll (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (5'(i)),
         .atan_val  (atan_q16(i)),
         .in_valid  (cr_valid[i]),
         .in_vec    (r_vec[i]),
         .out_valid (cr_valid[i+1]),
         .out_vec   (r_vec[i+1])
      );
      q2e_cordic_cell u_pitch (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (5'(i)),
         .atan_val  (atan_q16(i)),
         .in_valid  (cp_valid[i]),
         .in_vec    (p_vec[i]),
         .out_valid (cp_valid[i+1]),
         .out_vec   (p_vec[i+1])
      );
      q2e_cordic_cell u_yaw (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (5'(i)),
         .atan_val  (atan_q16(i)),
         .in_valid  (cy_valid[i]),
         .in_vec    (y_vec[i]),
         .out_valid (cy_valid[i+1]),
         .out_vec   (y_vec[i+1])
      );
   end

   // q.16 to q3.13 with rounding bias and clamp
   function automatic logic signed [15:0] to_q13(input logic signed [ZW+1:0] z,
                                                 input logic signed [15:0] lim);
      logic signed [ZW+1:0] v;
      logic signed [15:0]   o;
      v = (z + (ZW+2)'(4)) >>> 3;
      if (v > (ZW+2)'(lim)) begin
         o = lim;
      end else if (v < -(ZW+2)'(lim)) begin
         o = -lim;
      end else begin
         o = 16'(v);
      end
      return o;
   endfunction

   logic signed [ZW+1:0] zr, zp, zy;
   logic signed [15:0]   pitch_w;
   logic                 out_valid_ff;
   logic signed [15:0]   roll_ff, yaw_ff;
   logic signed [14:0]   pitch_ff;

   always_comb begin
      zr = r_vec[CORDIC_STAGES].zero ? '0 : (ZW+2)'(r_vec[CORDIC_STAGES].z);
      zy = y_vec[CORDIC_STAGES].zero ? '0 : (ZW+2)'(y_vec[CORDIC_STAGES].z);
      zp = p_vec[CORDIC_STAGES].zero ? '0 : (ZW+2)'(p_vec[CORDIC_STAGES].z);
      zp = (zp <<< 1) - (ZW+2)'(HALF_PI_Q16);
      pitch_w = to_q13(zp, HALF_PI_Q13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= cr_valid[CORDIC_STAGES] && cp_valid[CORDIC_STAGES]
                         && cy_valid[CORDIC_STAGES];
      end
      roll_ff  <= to_q13(zr, PI_Q13);
      yaw_ff   <= to_q13(zy, PI_Q13);
      pitch_ff <= pitch_w[14:0];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_roll  = roll_ff;
   assign rsp_pitch = pitch_ff;
   assign rsp_yaw   = yaw_ff;

`ifndef SYNTHESIS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(LATENCY) rsp_valid)
      else $error("item did not come out after the pipeline latency");

   a_pitch_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch <= 15'sd12868) && (rsp_pitch >= -15'sd12868))
      else $error("pitch beyond half pi");

   a_roll_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll <= PI_Q13) && (rsp_roll >= -PI_Q13)
                    && (rsp_yaw <= PI_Q13) && (rsp_yaw >= -PI_Q13))
      else $error("roll or yaw beyond pi");
`endif

endmodule
`default_nettype wire
